>>> hw/rtl/cle_pkg.sv
// cle_pkg: constants, codes and shared types of the canonical line editor
// no dependencies; used by the interfaces, the sequencer, the counter unit and the top level
`timescale 1ns / 1ps

package cle_pkg;

   localparam int LINE_CAPACITY = 32;
   localparam int ByteW = 8;
   localparam int LenW = $clog2(LINE_CAPACITY + 1);
   localparam int IdxW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam int CsrIdxW = 8;
   localparam int CsrDataW = 8;

   // character codes
   localparam logic [ByteW-1:0] CH_BS = 8'h08;
   localparam logic [ByteW-1:0] CH_DEL = 8'h7F;
   localparam logic [ByteW-1:0] CH_LF = 8'h0A;
   localparam logic [ByteW-1:0] CH_SPACE = 8'h20;

   // result channel tags
   localparam logic CHAN_ECHO = 1'b0;
   localparam logic CHAN_DOWN = 1'b1;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_CANONICAL_MODE = 8'd0;
   localparam logic [CsrIdxW-1:0] CSR_ECHO_ENABLE = 8'd1;

   // kind of item being worked on
   localparam logic [1:0] KIND_RAW = 2'd0;
   localparam logic [1:0] KIND_PLAIN = 2'd1;
   localparam logic [1:0] KIND_LF = 2'd2;

   typedef struct packed {
      logic [LenW-1:0] a;
      logic dec;
      logic [LenW-1:0] bound;
   } cle_unit_req_type;

   typedef struct packed {
      logic [LenW-1:0] sum;
      logic sum_eq;
      logic a_lt;
   } cle_unit_rsp_type;

   typedef struct packed {
      logic we;
      logic [IdxW-1:0] waddr;
      logic [ByteW-1:0] wdata;
      logic re;
      logic [IdxW-1:0] raddr;
   } cle_ram_req_type;

endpackage

>>> hw/rtl/cle_if.sv
// cle channel interfaces: input byte, result and register write channels
// depends on cle_pkg for field widths
`timescale 1ns / 1ps

interface cle_req_if;
   logic valid;
   logic ready;
   logic [cle_pkg::ByteW-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface cle_rsp_if;
   logic valid;
   logic ready;
   logic out_channel;
   logic [cle_pkg::ByteW-1:0] out_byte;
   logic last_of_run;

   modport source (output valid, output out_channel, output out_byte, output last_of_run,
                   input ready);
   modport sink (input valid, input out_channel, input out_byte, input last_of_run,
                 output ready);
endinterface

interface cle_csr_if;
   logic valid;
   logic ready;
   logic [cle_pkg::CsrIdxW-1:0] index;
   logic [cle_pkg::CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/canonical_line_editor.sv
// canonical_line_editor: top level with register bank, sequencer and line store
// depends on cle_pkg, cle_if, cle_ram, cle_cnt_unit and cle_seq
// an ordinary byte, an erase or a raw byte that gives results moves the sequencer out of idle;
// ready stays low until it is back in idle, and output stalls delay each result on the way
// line feed: echo if on, a store read state if the line is not empty, stored bytes one per cycle
// unless the output stalls, then the line feed; the single read port of the line store sets this order
// reset: sequencer idle, line length zero, canonical and echo on; store contents undefined
`timescale 1ns / 1ps

module canonical_line_editor (
   input  logic       clock,
   input  logic       reset,
   cle_req_if.sink    req_bus,
   cle_rsp_if.source  rsp_bus,
   cle_csr_if.sink    csr_bus
);

   logic canonical_ff;
   logic echo_ff;
   logic csr_write;

   cle_pkg::cle_ram_req_type ram_req;
   logic [cle_pkg::ByteW-1:0] ram_rdata;

   assign csr_bus.ready = 1'b1;
   assign csr_write = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         canonical_ff <= 1'b1;
         echo_ff <= 1'b1;
      end else if (csr_write) begin
         if (csr_bus.index == cle_pkg::CSR_CANONICAL_MODE) begin
            canonical_ff <= csr_bus.data[0];
         end else if (csr_bus.index == cle_pkg::CSR_ECHO_ENABLE) begin
            echo_ff <= csr_bus.data[0];
         end
      end
   end

   cle_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .canonical_mode (canonical_ff),
      .echo_enable    (echo_ff),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata)
   );

   cle_ram #(
      .WIDTH (cle_pkg::ByteW),
      .DEPTH (cle_pkg::LINE_CAPACITY)
   ) u_line_store (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

endmodule

>>> hw/rtl/cle_ram.sv
// cle_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds while re is low
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/cle_cnt_unit.sv
// cle_cnt_unit: shared step-and-compare unit for line length and read index
// depends on cle_pkg
`timescale 1ns / 1ps

module cle_cnt_unit (
   input  cle_pkg::cle_unit_req_type op,
   output cle_pkg::cle_unit_rsp_type res
);

   logic [cle_pkg::LenW-1:0] sum;

   always_comb begin
      if (op.dec) begin
         sum = op.a - cle_pkg::LenW'(1);
      end else begin
         sum = op.a + cle_pkg::LenW'(1);
      end
   end

   assign res.sum = sum;
   assign res.sum_eq = (sum == op.bound);
   assign res.a_lt = (op.a < op.bound);

endmodule

>>> hw/rtl/cle_seq.sv
// cle_seq: sequencer of the line editor, line length, output register
// depends on cle_pkg, cle_if and cle_cnt_unit
`timescale 1ns / 1ps

module cle_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      canonical_mode,
   input  logic                      echo_enable,
   cle_req_if.sink                   req_bus,
   cle_rsp_if.source                 rsp_bus,
   output cle_pkg::cle_ram_req_type  ram_req,
   input  logic [cle_pkg::ByteW-1:0] ram_rdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ECHO = 3'd1;
   localparam logic [2:0] S_BS1 = 3'd2;
   localparam logic [2:0] S_SP = 3'd3;
   localparam logic [2:0] S_BS2 = 3'd4;
   localparam logic [2:0] S_RD = 3'd5;
   localparam logic [2:0] S_DRAIN = 3'd6;
   localparam logic [2:0] S_LAST = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [cle_pkg::ByteW-1:0] byte_ff, byte_in;
   logic [1:0] kind_ff, kind_in;
   logic [cle_pkg::LenW-1:0] len_ff, len_in;
   logic [cle_pkg::IdxW-1:0] idx_ff, idx_in;

   logic rsp_valid_ff;
   logic chan_ff;
   logic [cle_pkg::ByteW-1:0] obyte_ff;
   logic last_ff;

   logic out_free;
   logic load;
   logic load_chan;
   logic [cle_pkg::ByteW-1:0] load_byte;
   logic load_last;
   logic accept;

   cle_pkg::cle_unit_req_type unit_req;
   cle_pkg::cle_unit_rsp_type unit_rsp;

   cle_cnt_unit u_cnt (
      .op  (unit_req),
      .res (unit_rsp)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      byte_in = byte_ff;
      kind_in = kind_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      load = 1'b0;
      load_chan = cle_pkg::CHAN_ECHO;
      load_byte = byte_ff;
      load_last = 1'b0;
      unit_req.a = len_ff;
      unit_req.dec = 1'b0;
      unit_req.bound = cle_pkg::LenW'(cle_pkg::LINE_CAPACITY);
      ram_req.we = 1'b0;
      ram_req.waddr = len_ff[cle_pkg::IdxW-1:0];
      ram_req.wdata = req_bus.in_byte;
      ram_req.re = 1'b0;
      ram_req.raddr = idx_ff;

      case (state_ff)
         S_IDLE: begin
            unit_req.dec = req_bus.in_byte inside {cle_pkg::CH_BS, cle_pkg::CH_DEL};
            if (accept) begin
               byte_in = req_bus.in_byte;
               if (!canonical_mode) begin
                  kind_in = cle_pkg::KIND_RAW;
                  state_in = echo_enable ? S_ECHO : S_LAST;
               end else if (req_bus.in_byte inside {cle_pkg::CH_BS, cle_pkg::CH_DEL}) begin
                  // erase on an empty line does nothing
                  if (len_ff != '0) begin
                     len_in = unit_rsp.sum;
                     if (echo_enable) begin
                        state_in = S_BS1;
                     end
                  end
               end else if (req_bus.in_byte == cle_pkg::CH_LF) begin
                  kind_in = cle_pkg::KIND_LF;
                  idx_in = '0;
                  if (echo_enable) begin
                     state_in = S_ECHO;
                  end else if (len_ff != '0) begin
                     state_in = S_RD;
                  end else begin
                     state_in = S_LAST;
                  end
               end else begin
                  kind_in = cle_pkg::KIND_PLAIN;
                  // full line drops the byte silently
                  if (unit_rsp.a_lt) begin
                     ram_req.we = 1'b1;
                     len_in = unit_rsp.sum;
                     if (echo_enable) begin
                        state_in = S_ECHO;
                     end
                  end
               end
            end
         end
         S_ECHO: begin
            if (out_free) begin
               load = 1'b1;
               load_chan = cle_pkg::CHAN_ECHO;
               load_byte = byte_ff;
               load_last = (kind_ff == cle_pkg::KIND_PLAIN);
               if (kind_ff == cle_pkg::KIND_PLAIN) begin
                  state_in = S_IDLE;
               end else if (kind_ff == cle_pkg::KIND_LF && len_ff != '0) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_LAST;
               end
            end
         end
         S_BS1: begin
            if (out_free) begin
               load = 1'b1;
               load_byte = cle_pkg::CH_BS;
               state_in = S_SP;
            end
         end
         S_SP: begin
            if (out_free) begin
               load = 1'b1;
               load_byte = cle_pkg::CH_SPACE;
               state_in = S_BS2;
            end
         end
         S_BS2: begin
            if (out_free) begin
               load = 1'b1;
               load_byte = cle_pkg::CH_BS;
               load_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            ram_req.re = 1'b1;
            ram_req.raddr = idx_ff;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            unit_req.a = cle_pkg::LenW'(idx_ff);
            unit_req.bound = len_ff;
            if (out_free) begin
               load = 1'b1;
               load_chan = cle_pkg::CHAN_DOWN;
               load_byte = ram_rdata;
               if (unit_rsp.sum_eq) begin
                  state_in = S_LAST;
               end else begin
                  // fetch the next stored byte while this one goes out
                  ram_req.re = 1'b1;
                  ram_req.raddr = unit_rsp.sum[cle_pkg::IdxW-1:0];
                  idx_in = unit_rsp.sum[cle_pkg::IdxW-1:0];
               end
            end
         end
         S_LAST: begin
            if (out_free) begin
               load = 1'b1;
               load_chan = cle_pkg::CHAN_DOWN;
               load_byte = byte_ff;
               load_last = 1'b1;
               if (kind_ff == cle_pkg::KIND_LF) begin
                  len_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      idx_ff <= idx_in;
      if (load) begin
         chan_ff <= load_chan;
         obyte_ff <= load_byte;
         last_ff <= load_last;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_channel = chan_ff;
   assign rsp_bus.out_byte = obyte_ff;
   assign rsp_bus.last_of_run = last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= cle_pkg::LenW'(cle_pkg::LINE_CAPACITY))
      else $error("line length above capacity");

   a_drain_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (cle_pkg::LenW'(idx_ff) < len_ff))
      else $error("drain index past line length");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |=> (state_ff == S_IDLE))
      else $error("final result without return to idle");

   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LAST && out_free && kind_ff == cle_pkg::KIND_LF) |=> (len_ff == '0))
      else $error("line not cleared after line feed");

   a_no_load_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !load)
      else $error("result overwritten while stalled");

endmodule

>>> bench/cle_line_check.sv
`timescale 1ns / 1ps
// cle_line_check: watches the input, result and register channels of the line editor,
// predicts every result item from its own copy of the line and compares them in order
// depends on cle_pkg and the channel interfaces in cle_if

module cle_line_check (
   input  logic clock,
   input  logic reset,
   cle_req_if   req_bus,
   cle_rsp_if   rsp_bus,
   cle_csr_if   csr_bus,
   output int   fail_count,
   output int   pending_count,
   output int   result_count
);
   import cle_pkg::*;

   typedef struct packed {
      logic             ch;
      logic [ByteW-1:0] data;
      logic             last;
   } tty_out_type;

   tty_out_type      predicted_bytes[$];
   logic [ByteW-1:0] line_copy [LINE_CAPACITY];
   int               line_fill;
   logic             canon_on;
   logic             echo_on;

   // everything one received byte causes, last_of_run set on the final item
   task automatic edit_line(input logic [ByteW-1:0] b);
      tty_out_type run[$];
      if (!canon_on) begin
         if (echo_on) run.push_back('{CHAN_ECHO, b, 1'b0});
         run.push_back('{CHAN_DOWN, b, 1'b0});
      end else if (b == CH_BS || b == CH_DEL) begin
         if (line_fill > 0) begin
            line_fill--;
            if (echo_on) begin
               run.push_back('{CHAN_ECHO, CH_BS, 1'b0});
               run.push_back('{CHAN_ECHO, CH_SPACE, 1'b0});
               run.push_back('{CHAN_ECHO, CH_BS, 1'b0});
            end
         end
      end else if (b == CH_LF) begin
         if (echo_on) run.push_back('{CHAN_ECHO, b, 1'b0});
         for (int i = 0; i < line_fill; i++) run.push_back('{CHAN_DOWN, line_copy[i], 1'b0});
         run.push_back('{CHAN_DOWN, b, 1'b0});
         line_fill = 0;
      end else if (line_fill < LINE_CAPACITY) begin
         if (echo_on) run.push_back('{CHAN_ECHO, b, 1'b0});
         line_copy[line_fill] = b;
         line_fill++;
      end
      // a full line drops the byte with nothing to show
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[k]) predicted_bytes.push_back(run[k]);
   endtask

   task automatic check_result();
      tty_out_type got;
      tty_out_type want;
      got = '{rsp_bus.out_channel, rsp_bus.out_byte, rsp_bus.last_of_run};
      result_count++;
      if (predicted_bytes.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected result at %0t: chan %0d byte %h last %0d",
                     $time, got.ch, got.data, got.last);
      end else begin
         want = predicted_bytes.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"mismatch at %0t: expected chan %0d byte %h last %0d,",
                         " got chan %0d byte %h last %0d"},
                        $time, want.ch, want.data, want.last, got.ch, got.data, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         predicted_bytes.delete();
         line_fill = 0;
         canon_on = 1'b1;
         echo_on = 1'b1;
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_CANONICAL_MODE) canon_on = csr_bus.data[0];
            else if (csr_bus.index == CSR_ECHO_ENABLE) echo_on = csr_bus.data[0];
         end
         if (req_bus.valid && req_bus.ready) edit_line(req_bus.in_byte);
         if (rsp_bus.valid && rsp_bus.ready) check_result();
      end
      pending_count = predicted_bytes.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// tb: top of the line editor bench; drives bytes, register writes and output stalls,
// the checking is done by cle_line_check; depends on cle_pkg, cle_if and the block

module tb;
   import cle_pkg::*;

   localparam int DRAIN_CYCLES = LINE_CAPACITY + 20;
   localparam int PHASE_ITEMS = 32;

   // register indexes that the block does not decode
   localparam logic [CsrIdxW-1:0] CSR_UNKNOWN_NEXT = CSR_ECHO_ENABLE + CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CSR_UNKNOWN_TOP = '1;

   logic clock;
   logic reset;

   cle_req_if req_bus ();
   cle_rsp_if rsp_bus ();
   cle_csr_if csr_bus ();

   int fail_count;
   int pending_count;
   int result_count;

   int items_sent = 0;
   int settings_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_stamp = 0;
   int hold_seen = 0;
   int hold_left = 0;

   canonical_line_editor dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cle_line_check line_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // output side: random stalls, plus a long hold-off when the stimulus asks for one
   always @(negedge clock) begin
      if (hold_stamp != hold_seen) begin
         hold_seen = hold_stamp;
         hold_left = 150;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // stop sending and wait until the block has nothing left to say
   task automatic wait_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      settings_count++;
   endtask

   // upper bits are noise, only bit 0 matters
   task automatic set_modes(input logic canon, input logic echo);
      logic [CsrDataW-1:0] junk;
      junk = CsrDataW'($urandom_range(255));
      write_reg(CSR_CANONICAL_MODE, {junk[CsrDataW-1:1], canon});
      junk = CsrDataW'($urandom_range(255));
      write_reg(CSR_ECHO_ENABLE, {junk[CsrDataW-1:1], echo});
   endtask

   // a typed line with occasional erases, ended by a line feed
   task automatic send_line(input int max_len);
      int n;
      logic [ByteW-1:0] c;
      n = $urandom_range(max_len);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < 12) begin
            c = $urandom_range(1) ? CH_BS : CH_DEL;
         end else begin
            do c = ByteW'($urandom_range(255)); while (c == CH_BS || c == CH_DEL || c == CH_LF);
         end
         send_byte(c);
      end
      send_byte(CH_LF);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 55; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 55; end
         default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
   endtask

   initial begin
      logic phase_canon [8];
      logic phase_echo [8];
      int start_items;
      int r;
      phase_canon = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      phase_echo  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: canonical with echo, as after reset
      send_byte(CH_LF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h41);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_LF);
      send_byte(CH_BS);
      wait_drain();
      write_reg(CSR_ECHO_ENABLE, 8'hFE);
      send_byte(8'h78);
      send_byte(8'h79);
      send_byte(CH_BS);
      send_byte(CH_LF);
      send_byte(CH_DEL);
      wait_drain();
      write_reg(CSR_ECHO_ENABLE, 8'h01);
      send_byte(8'h71);
      send_byte(8'h72);
      wait_drain();
      // raw mode must leave the partial line alone
      write_reg(CSR_CANONICAL_MODE, 8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_LF);
      wait_drain();
      write_reg(CSR_ECHO_ENABLE, 8'h00);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_LF);
      wait_drain();
      write_reg(CSR_CANONICAL_MODE, 8'hFF);
      write_reg(CSR_ECHO_ENABLE, 8'hFF);
      send_byte(8'h7A);
      wait_drain();
      // unknown register indexes change nothing
      write_reg(CSR_UNKNOWN_NEXT, 8'h00);
      write_reg(CSR_UNKNOWN_TOP, 8'h00);
      send_byte(CH_LF);

      // overfull line while the output is held off, so the input backs up
      wait_drain();
      hold_stamp++;
      for (int k = 0; k < LINE_CAPACITY + 4; k++) send_byte(ByteW'($urandom_range(8'h7E, 8'h20)));
      send_byte(CH_LF);

      for (int p = 0; p < 8; p++) begin
         wait_drain();
         set_modes(phase_canon[p], phase_echo[p]);
         set_idling(p % 4);
         start_items = items_sent;
         while (items_sent - start_items < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 10) send_byte(ByteW'($urandom_range(255)));
            else if (r < 22) send_line(LINE_CAPACITY + 8);
            else send_line(8);
         end
      end

      wait_drain();
      $display("sent %0d input items, checked %0d result items", items_sent, result_count);
      $display("%0d register writes across raw, canonical, echo on and off, four idle mixes",
               settings_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> canonical_line_editor.f
hw/rtl/cle_pkg.sv
hw/rtl/cle_if.sv
hw/rtl/cle_ram.sv
hw/rtl/cle_cnt_unit.sv
hw/rtl/cle_seq.sv
hw/rtl/canonical_line_editor.sv
bench/cle_line_check.sv
bench/tb.sv
